// ===== rtl/point_cloud_rigid_transform_core_macros.svh =====
// Assertion macros for the point cloud transform checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef POINT_CLOUD_RIGID_TRANSFORM_CORE_MACROS_SVH
`define POINT_CLOUD_RIGID_TRANSFORM_CORE_MACROS_SVH

`define PCRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== rtl/pcrt_pkg.sv =====
// Types, state codes and constants shared by the point cloud transform core.
// No dependencies.
package pcrt_pkg;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic  cmd;
    word_t pose_tx;
    word_t pose_ty;
    word_t pose_tz;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t quat_w;
    word_t point_x;
    word_t point_y;
    word_t point_z;
    logic  last_point;
  } in_beat_t;

  typedef struct packed {
    word_t world_x;
    word_t world_y;
    word_t world_z;
    logic  dropped;
    logic  saturated;
    logic  last_out;
  } out_beat_t;

  typedef struct packed {
    word_t px;
    word_t py;
    word_t pz;
    logic  drop;
    logic  last;
  } pt_t;

  typedef struct packed {
    word_t [8:0] rot;
    word_t [2:0] trans;
  } xform_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DRAIN, ST_MUL, ST_NUM, ST_DIV, ST_PUSH
  } fstate_e;

  localparam logic  CMD_POSE  = 1'b0;
  localparam logic  CMD_POINT = 1'b1;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam int    NUM_PROD  = 10;
  localparam int    NUM_ROT   = 9;
  localparam int    DIV_STEPS = 32;

  // product order: xx yy zz ww xy zw xz yw yz xw
  localparam logic [1:0] MUL_A [NUM_PROD] =
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1, 2'd0};
  localparam logic [1:0] MUL_B [NUM_PROD] =
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3, 2'd2, 2'd3};

  function automatic logic [31:0] mag32(word_t v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== rtl/pcrt_if.sv =====
// Valid/ready channel interfaces for input and result beats.
// Depends on pcrt_pkg.
interface pcrt_in_if import pcrt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t payload;
  modport src (output valid, output payload, input ready);
  modport snk (input valid, input payload, output ready);
endinterface

interface pcrt_out_if import pcrt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t payload;
  modport src (output valid, output payload, input ready);
  modport snk (input valid, input payload, output ready);
endinterface

// ===== rtl/point_cloud_rigid_transform_core.sv =====
// Point cloud rigid transform core: front end, point queue, back end.
// Depends on pcrt_pkg, pcrt_if, pcrt_fifo, pcrt_front, pcrt_back.
// Points pass the queue, then back end product, sum and output registers; one point beat
// per cycle while out_o.ready holds and no rotation is computed. First point of a cloud
// with a valid pose: back end drains, then products, numerators and norm, division, push.
// Reset clears control state, pose flags and queue; rotation is undefined until latched.
module point_cloud_rigid_transform_core import pcrt_pkg::*; #(
  parameter int FifoDepth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic   cfg_data_i,
  pcrt_in_if.snk  in_i,
  pcrt_out_if.src out_o
);
  logic       enable_q;
  logic       push, pop, empty, full;
  pt_t        push_data, head;
  back_stat_t bstat;
  xform_t     xform;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) enable_q <= 1'b0;
    else if (cfg_we_i) enable_q <= cfg_data_i;
  end

  pcrt_front u_front (
    .clk_i, .rst_ni, .in_i,
    .push_o(push), .push_data_o(push_data),
    .fifo_full_i(full), .fifo_empty_i(empty),
    .back_stat_i(bstat), .xform_o(xform)
  );

  pcrt_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .head_o(head), .empty_o(empty), .full_o(full)
  );

  pcrt_back u_back (
    .clk_i, .rst_ni,
    .transform_enable_i(enable_q), .xform_i(xform),
    .head_i(head), .empty_i(empty), .pop_o(pop),
    .stat_o(bstat), .out_o
  );
endmodule

// ===== rtl/pcrt_fifo.sv =====
// Small point queue between front and back.
// Depends on pcrt_pkg.
module pcrt_fifo import pcrt_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pt_t  push_data_i,
  input  logic pop_i,
  output pt_t  head_o,
  output logic empty_o,
  output logic full_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pt_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end
endmodule

// ===== rtl/pcrt_front.sv =====
// Front end: accepts beats, holds the latest pose, latches the rotation at cloud start.
// Depends on pcrt_pkg and pcrt_if.
module pcrt_front import pcrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcrt_in_if.snk     in_i,
  output logic       push_o,
  output pt_t        push_data_o,
  input  logic       fifo_full_i,
  input  logic       fifo_empty_i,
  input  back_stat_t back_stat_i,
  output xform_t     xform_o
);
  fstate_e state_q, state_d;

  word_t lt_q [3];
  word_t lq_q [4];
  word_t hq_q [4];
  logic  pose_seen_q, cloud_open_q, cloud_dropped_q;
  pt_t   held_q;
  logic signed [63:0] prod_q [NUM_PROD];
  logic signed [63:0] num_q [NUM_ROT];
  logic [63:0] den_q, rem_q;
  logic [31:0] quo_q;
  logic [3:0]  k_q, e_q;
  logic [4:0]  s_q;
  word_t rot_q [NUM_ROT];
  word_t trans_q [3];

  logic in_fire, first, drop_now, big;
  logic [33:0] sum_abs;
  logic signed [63:0] mp, numsel;
  logic [63:0] magn, r, rem_n;
  logic ge;
  logic [31:0] quo_n;
  logic [32:0] rnd;
  in_beat_t b;

  function automatic word_t halve(word_t v);
    logic [31:0] m;
    m = mag32(v) >> 1;
    halve = v[31] ? word_t'(~m + 32'd1) : word_t'(m);
  endfunction

  assign b       = in_i.payload;
  assign in_fire = in_i.valid && in_i.ready;
  assign first   = (b.cmd == CMD_POINT) && !cloud_open_q;
  assign sum_abs = 34'(mag32(lq_q[0])) + 34'(mag32(lq_q[1]))
                 + 34'(mag32(lq_q[2])) + 34'(mag32(lq_q[3]));
  assign drop_now = !pose_seen_q || (sum_abs <= 34'd1);
  assign big = (mag32(lq_q[0]) > ONE_Q30) || (mag32(lq_q[1]) > ONE_Q30)
            || (mag32(lq_q[2]) > ONE_Q30) || (mag32(lq_q[3]) > ONE_Q30);

  assign mp     = hq_q[MUL_A[k_q]] * hq_q[MUL_B[k_q]];
  assign numsel = num_q[e_q];
  assign magn   = numsel[63] ? (~numsel + 64'd1) : numsel;
  assign r      = (s_q == '0) ? magn : {rem_q[62:0], 1'b0};
  assign ge     = (r >= den_q);
  assign rem_n  = ge ? (r - den_q) : r;
  assign quo_n  = (s_q == '0) ? {31'd0, ge} : {quo_q[30:0], ge};
  assign rnd    = ({1'b0, quo_n} + 33'd1) >> 1;

  always_comb begin
    for (int i = 0; i < NUM_ROT; i++) xform_o.rot[i] = rot_q[i];
    for (int i = 0; i < 3; i++) xform_o.trans[i] = trans_q[i];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire && first && !drop_now) state_d = ST_DRAIN;
      ST_DRAIN: if (fifo_empty_i && !back_stat_i.busy) state_d = ST_MUL;
      ST_MUL:   if (k_q == 4'(NUM_PROD - 1)) state_d = ST_NUM;
      ST_NUM:   state_d = ST_DIV;
      ST_DIV:   if (s_q == 5'(DIV_STEPS - 1) && e_q == 4'(NUM_ROT - 1)) state_d = ST_PUSH;
      ST_PUSH:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    push_o      = 1'b0;
    push_data_o = held_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready  = !fifo_full_i;
        push_o      = in_fire && (b.cmd == CMD_POINT) && (cloud_open_q || drop_now);
        push_data_o = '{px: b.point_x, py: b.point_y, pz: b.point_z,
                        drop: cloud_open_q ? cloud_dropped_q : 1'b1,
                        last: b.last_point};
      end
      ST_PUSH: push_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      pose_seen_q     <= 1'b0;
      cloud_open_q    <= 1'b0;
      cloud_dropped_q <= 1'b0;
      k_q             <= '0;
      e_q             <= '0;
      s_q             <= '0;
      for (int i = 0; i < 3; i++) lt_q[i] <= '0;
      lq_q[0] <= '0;
      lq_q[1] <= '0;
      lq_q[2] <= '0;
      lq_q[3] <= word_t'(ONE_Q30);
    end else begin
      state_q <= state_d;
      if (in_fire && b.cmd == CMD_POSE) begin
        lt_q[0] <= b.pose_tx;
        lt_q[1] <= b.pose_ty;
        lt_q[2] <= b.pose_tz;
        lq_q[0] <= b.quat_x;
        lq_q[1] <= b.quat_y;
        lq_q[2] <= b.quat_z;
        lq_q[3] <= b.quat_w;
        pose_seen_q <= 1'b1;
      end
      if (in_fire && b.cmd == CMD_POINT) begin
        cloud_open_q <= !b.last_point;
        if (first) cloud_dropped_q <= drop_now;
      end
      if (state_q == ST_DRAIN) begin
        k_q <= '0;
        e_q <= '0;
        s_q <= '0;
      end
      if (state_q == ST_MUL) k_q <= k_q + 4'd1;
      if (state_q == ST_DIV) begin
        s_q <= s_q + 5'd1;
        if (s_q == 5'(DIV_STEPS - 1)) e_q <= e_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && first) begin
      for (int i = 0; i < 4; i++) hq_q[i] <= big ? halve(lq_q[i]) : lq_q[i];
      held_q <= '{px: b.point_x, py: b.point_y, pz: b.point_z, drop: 1'b0,
                  last: b.last_point};
    end
    if (state_q == ST_MUL) prod_q[k_q] <= mp;
    if (state_q == ST_NUM) begin
      num_q[0] <= prod_q[0] + prod_q[3] - prod_q[1] - prod_q[2];
      num_q[1] <= (prod_q[4] - prod_q[5]) <<< 1;
      num_q[2] <= (prod_q[6] + prod_q[7]) <<< 1;
      num_q[3] <= (prod_q[4] + prod_q[5]) <<< 1;
      num_q[4] <= prod_q[1] + prod_q[3] - prod_q[0] - prod_q[2];
      num_q[5] <= (prod_q[8] - prod_q[9]) <<< 1;
      num_q[6] <= (prod_q[6] - prod_q[7]) <<< 1;
      num_q[7] <= (prod_q[8] + prod_q[9]) <<< 1;
      num_q[8] <= prod_q[2] + prod_q[3] - prod_q[0] - prod_q[1];
      den_q    <= prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3];
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (s_q == 5'(DIV_STEPS - 1))
        rot_q[e_q] <= numsel[63] ? word_t'(~rnd[31:0] + 32'd1) : word_t'(rnd[31:0]);
    end
    if (state_q == ST_PUSH)
      for (int i = 0; i < 3; i++) trans_q[i] <= lt_q[i];
  end
endmodule

// ===== rtl/pcrt_back.sv =====
// Back end: transforms queued points if enabled, saturates, drives result beats.
// Depends on pcrt_pkg and pcrt_if.
module pcrt_back import pcrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       transform_enable_i,
  input  xform_t     xform_i,
  input  pt_t        head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output back_stat_t stat_o,
  pcrt_out_if.src    out_o
);
  logic adv;
  logic s1_v_q, s2_v_q, out_v_q;
  logic signed [63:0] pr_q [3][3];
  pt_t  s1_pt_q, s2_pt_q;
  logic s1_en_q, s2_en_q;
  logic signed [35:0] t_q [3];
  word_t hp [3];
  word_t pp [3];
  logic signed [65:0] sum [3];
  logic signed [37:0] v [3];
  out_beat_t out_q, out_d;
  word_t w [3];
  logic sat;

  assign adv         = !out_v_q || out_o.ready;
  assign pop_o       = adv && !empty_i;
  assign stat_o.busy = s1_v_q || s2_v_q;
  assign out_o.valid = out_v_q;
  assign out_o.payload = out_q;

  assign hp[0] = head_i.px;
  assign hp[1] = head_i.py;
  assign hp[2] = head_i.pz;
  assign pp[0] = s2_pt_q.px;
  assign pp[1] = s2_pt_q.py;
  assign pp[2] = s2_pt_q.pz;

  always_comb begin
    for (int i = 0; i < 3; i++)
      sum[i] = pr_q[i][0] + pr_q[i][1] + pr_q[i][2] + 66'sd536870912;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v[i] = t_q[i] + $signed(xform_i.trans[i]);
      if (v[i][37:31] != {7{v[i][37]}}) begin
        sat  = 1'b1;
        w[i] = v[i][37] ? word_t'(32'h8000_0000) : word_t'(32'h7fff_ffff);
      end else begin
        w[i] = v[i][31:0];
      end
    end
    out_d.last_out = s2_pt_q.last;
    if (!s2_en_q) begin
      out_d.world_x = pp[0]; out_d.world_y = pp[1]; out_d.world_z = pp[2];
      out_d.dropped = 1'b0;  out_d.saturated = 1'b0;
    end else if (s2_pt_q.drop) begin
      out_d.world_x = '0; out_d.world_y = '0; out_d.world_z = '0;
      out_d.dropped = 1'b1; out_d.saturated = 1'b0;
    end else begin
      out_d.world_x = w[0]; out_d.world_y = w[1]; out_d.world_z = w[2];
      out_d.dropped = 1'b0; out_d.saturated = sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= !empty_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pr_q[i][j] <= $signed(xform_i.rot[3*i+j]) * hp[j];
      s1_pt_q <= head_i;
      s1_en_q <= transform_enable_i;
      for (int i = 0; i < 3; i++) t_q[i] <= 36'(sum[i] >>> 30);
      s2_pt_q <= s1_pt_q;
      s2_en_q <= s1_en_q;
      out_q   <= out_d;
    end
  end
endmodule

// ===== rtl/pcrt_chk.sv =====
// Port-level checker for the point cloud transform core, with its bind.
// Depends on pcrt_pkg and the assertion macro header.
`include "point_cloud_rigid_transform_core_macros.svh"

module pcrt_chk import pcrt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);
  `PCRT_ASSERT(a_drop_zero, out_valid && out_data.dropped |-> out_data.world_x == 0 && out_data.world_y == 0 && out_data.world_z == 0, "dropped beat with nonzero coordinates")
  `PCRT_ASSERT(a_drop_nosat, out_valid |-> !(out_data.dropped && out_data.saturated), "dropped and saturated together")
  `PCRT_ASSERT(a_sat_edge, out_valid && out_data.saturated |-> out_data.world_x == 32'sh7fffffff || out_data.world_x == 32'sh80000000 || out_data.world_y == 32'sh7fffffff || out_data.world_y == 32'sh80000000 || out_data.world_z == 32'sh7fffffff || out_data.world_z == 32'sh80000000, "saturated beat without clamped coordinate")
  `PCRT_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result beat changed")
endmodule

bind point_cloud_rigid_transform_core pcrt_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.payload)
);

// ===== test/testbench.sv =====
// Testbench for point_cloud_rigid_transform_core: directed and random pose/point beats,
// checked against a bit-exact predictor of the quaternion rigid transform.
// Depends on pcrt_pkg, pcrt_if and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import pcrt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;

  pcrt_in_if  in_i ();
  pcrt_out_if out_o ();

  point_cloud_rigid_transform_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o)
  );

  always #10 clk_i = ~clk_i;

  in_beat_t  beat_q[$];
  out_beat_t world_q[$];
  int        errors = 0;
  int        rcv_cnt = 0;
  bit        quiet = 1'b0;

  // transform state mirrored by the predictor
  bit          xf_en = 1'b0;
  bit          have_pose, cl_open, cl_drop;
  longint      lat_t[3], lat_q[4], act_r[9], act_t[3];

  function automatic longint q30_div(longint num, longint unsigned den);
    longint unsigned rem, q;
    rem = (num < 0) ? -num : num;
    q = 0;
    if (rem >= den) begin
      q = 1;
      rem -= den;
    end
    for (int i = 0; i < 31; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    q = (q + 1) >> 1;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint half_tz(longint v);
    return (v < 0) ? -((-v) >>> 1) : (v >>> 1);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic latch_pose();
    longint x, y, z, w;
    longint unsigned n;
    x = lat_q[0]; y = lat_q[1]; z = lat_q[2]; w = lat_q[3];
    if (!have_pose || (mag(x) + mag(y) + mag(z) + mag(w)) <= 1) begin
      cl_drop = 1'b1;
      return;
    end
    cl_drop = 1'b0;
    if (mag(x) > (64'sd1 << 30) || mag(y) > (64'sd1 << 30) ||
        mag(z) > (64'sd1 << 30) || mag(w) > (64'sd1 << 30)) begin
      x = half_tz(x); y = half_tz(y); z = half_tz(z); w = half_tz(w);
    end
    n = x*x + y*y + z*z + w*w;
    act_r[0] = q30_div(x*x + w*w - y*y - z*z, n);
    act_r[1] = q30_div(2*(x*y - z*w), n);
    act_r[2] = q30_div(2*(x*z + y*w), n);
    act_r[3] = q30_div(2*(x*y + z*w), n);
    act_r[4] = q30_div(y*y + w*w - x*x - z*z, n);
    act_r[5] = q30_div(2*(y*z - x*w), n);
    act_r[6] = q30_div(2*(x*z - y*w), n);
    act_r[7] = q30_div(2*(y*z + x*w), n);
    act_r[8] = q30_div(z*z + w*w - x*x - y*y, n);
    for (int i = 0; i < 3; i++) act_t[i] = lat_t[i];
  endtask

  task automatic predict_world(in_beat_t b);
    out_beat_t e;
    longint p[3], v[3], s;
    if (b.cmd == CMD_POSE) begin
      lat_t[0] = b.pose_tx; lat_t[1] = b.pose_ty; lat_t[2] = b.pose_tz;
      lat_q[0] = b.quat_x; lat_q[1] = b.quat_y; lat_q[2] = b.quat_z; lat_q[3] = b.quat_w;
      have_pose = 1'b1;
      return;
    end
    if (!cl_open) begin
      latch_pose();
      cl_open = 1'b1;
    end
    p[0] = b.point_x; p[1] = b.point_y; p[2] = b.point_z;
    e = '0;
    for (int i = 0; i < 3; i++) begin
      if (!xf_en) v[i] = p[i];
      else if (cl_drop) v[i] = 0;
      else begin
        s = act_r[3*i]*p[0] + act_r[3*i+1]*p[1] + act_r[3*i+2]*p[2];
        v[i] = ((s + (64'sd1 << 29)) >>> 30) + act_t[i];
        if (v[i] > 64'sd2147483647) begin
          v[i] = 64'sd2147483647; e.saturated = 1'b1;
        end
        if (v[i] < -64'sd2147483648) begin
          v[i] = -64'sd2147483648; e.saturated = 1'b1;
        end
      end
    end
    e.dropped = xf_en && cl_drop;
    e.world_x = v[0][31:0]; e.world_y = v[1][31:0]; e.world_z = v[2][31:0];
    e.last_out = b.last_point;
    if (b.last_point) cl_open = 1'b0;
    world_q.push_back(e);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, rcv_cnt);
    errors++;
  endtask

  // ---- driver ----
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
      in_i.payload <= '0;
    end else begin
      if (in_i.valid && in_i.ready) predict_world(in_i.payload);
      if (!in_i.valid || in_i.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_i.valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          in_i.valid <= 1'b1;
          in_i.payload <= beat_q.pop_front();
          if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 7);
        end else begin
          in_i.valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  int out_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t g, e;
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        g = out_o.payload;
        rcv_cnt++;
        if (world_q.size() == 0) begin
          report("unexpected beat", rcv_cnt, 0);
        end else begin
          e = world_q.pop_front();
          if (g.world_x !== e.world_x) report("world_x", g.world_x, e.world_x);
          if (g.world_y !== e.world_y) report("world_y", g.world_y, e.world_y);
          if (g.world_z !== e.world_z) report("world_z", g.world_z, e.world_z);
          if (g.dropped !== e.dropped) report("dropped", g.dropped, e.dropped);
          if (g.saturated !== e.saturated) report("saturated", g.saturated, e.saturated);
          if (g.last_out !== e.last_out) report("last_out", g.last_out, e.last_out);
        end
        if (rcv_cnt == 60 || rcv_cnt == 400) hold_cnt = 120;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_o.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_o.ready <= 1'b0;
      end else begin
        out_o.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 7);
      end
    end
  end

  // ---- stimulus ----
  function automatic word_t rnd_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3, 4: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t rnd_quat_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
    endcase
  endfunction

  task automatic add_pose(word_t tx, word_t ty, word_t tz,
                          word_t qx, word_t qy, word_t qz, word_t qw);
    in_beat_t b;
    b.cmd = CMD_POSE; b.last_point = 1'($urandom_range(0, 1));
    b.point_x = $urandom; b.point_y = $urandom; b.point_z = $urandom;
    b.pose_tx = tx; b.pose_ty = ty; b.pose_tz = tz;
    b.quat_x = qx; b.quat_y = qy; b.quat_z = qz; b.quat_w = qw;
    beat_q.push_back(b);
  endtask

  task automatic add_point(word_t x, word_t y, word_t z, logic last);
    in_beat_t b;
    b.cmd = CMD_POINT; b.last_point = last;
    b.pose_tx = $urandom; b.pose_ty = $urandom; b.pose_tz = $urandom;
    b.quat_x = $urandom; b.quat_y = $urandom; b.quat_z = $urandom; b.quat_w = $urandom;
    b.point_x = x; b.point_y = y; b.point_z = z;
    beat_q.push_back(b);
  endtask

  task automatic rnd_pose();
    word_t q[4];
    int k;
    k = $urandom_range(0, 19);
    for (int i = 0; i < 4; i++) q[i] = rnd_quat_comp();
    if (k == 0) q = '{0, 0, 0, 0};
    else if (k == 1) begin
      q = '{0, 0, 0, 0};
      q[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
    end else if (k == 2) begin
      q = '{0, 0, 0, 0};
      q[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 32'sd2 : 32'sh4000_0000;
    end
    add_pose(rnd_word(), rnd_word(), rnd_word(), q[0], q[1], q[2], q[3]);
  endtask

  task automatic gen_random(int n);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) != 0) begin
        rnd_pose();
        cnt++;
      end
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          rnd_pose();
          cnt++;
        end
        add_point(rnd_word(), rnd_word(), rnd_word(),
                  (i == len - 1) ? 1'b1 : ($urandom_range(0, 29) == 0));
        cnt++;
      end
    end
  endtask

  task automatic write_enable(bit v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    xf_en = v;
  endtask

  task automatic settle();
    while (beat_q.size() != 0 || in_i.valid || world_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  initial begin
    have_pose = 0; cl_open = 0; cl_drop = 0;
    lat_t = '{0, 0, 0};
    lat_q = '{0, 0, 0, 64'sd1 << 30};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_enable(1'b1);
    add_point(32'sd65536, -32'sd65536, 32'sd0, 1'b0);        // no pose yet
    add_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, 1'b1);
    add_pose(32'sd65536, -32'sd131072, 32'sd0, 0, 0, 0, 32'sh4000_0000);
    add_point(32'sd65536, 32'sd131072, -32'sd196608, 1'b0);
    add_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    add_pose(32'sd1, 32'sd2, 32'sd3, 0, 0, 0, 0);                // zero quaternion
    add_point(32'sd100, 32'sd200, 32'sd300, 1'b1);
    add_pose(32'sd0, 32'sd0, 32'sd0, 0, -32'sd1, 0, 0);          // raw norm too small
    add_point(32'sd100, 32'sd200, 32'sd300, 1'b1);
    add_pose(32'sh7fff_ffff, 32'sh8000_0000, 32'sd0,            // large quaternion
             32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    add_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    add_pose(32'sd0, 32'sd0, 32'sd0, 0, 32'sh2d41_3ccd, 0, 32'sh2d41_3ccd);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    add_point(32'sd65536, 32'sd65536, 32'sd65536, 1'b1);        // one point cloud
    add_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 32'sh4000_0000);
    add_point(32'sh0100_0000, 32'sd0, -32'sh0100_0000, 1'b1);  // saturates
    settle();

    write_enable(1'b0);
    add_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 1'b0);
    add_point(-32'sd1, 32'sd1, 32'sh1234_5678, 1'b1);
    gen_random(150);
    settle();

    write_enable(1'b1);
    gen_random(600);
    settle();

    write_enable(1'b0);
    write_enable(1'b1);
    quiet = 1'b1;
    gen_random(150);
    settle();

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
